>>> hdl/smx_pkg.sv
package smx_pkg;

  localparam int DATA_DEPTH_DEF   = 64;
  localparam int CALL_DEPTH_DEF   = 64;
  localparam int GLOBAL_DEPTH_DEF = 64;
  localparam int PROG_DEPTH_DEF   = 1024;

  localparam int IN_W   = 40;
  localparam int CFG_W  = 11;
  localparam int ENT_W  = 34;

  localparam logic [5:0] OP_PUSH  = 6'd0;
  localparam logic [5:0] OP_RET   = 6'd1;
  localparam logic [5:0] OP_RCL   = 6'd2;
  localparam logic [5:0] OP_END   = 6'd3;
  localparam logic [5:0] OP_RCE   = 6'd4;
  localparam logic [5:0] OP_FREE  = 6'd5;
  localparam logic [5:0] OP_ALLOC = 6'd6;
  localparam logic [5:0] OP_JMP   = 6'd7;
  localparam logic [5:0] OP_REC   = 6'd8;
  localparam logic [5:0] OP_DEP   = 6'd9;
  localparam logic [5:0] OP_ATAC  = 6'd10;
  localparam logic [5:0] OP_MOV   = 6'd11;
  localparam logic [5:0] OP_POP   = 6'd12;
  localparam logic [5:0] OP_DUP   = 6'd13;
  localparam logic [5:0] OP_STO   = 6'd14;
  localparam logic [5:0] OP_STL   = 6'd15;
  localparam logic [5:0] OP_JIT   = 6'd16;
  localparam logic [5:0] OP_JIF   = 6'd17;
  localparam logic [5:0] OP_CALL  = 6'd18;
  localparam logic [5:0] OP_PRN   = 6'd19;
  localparam logic [5:0] OP_TOP   = 6'd20;
  localparam logic [5:0] OP_SAVE  = 6'd21;
  localparam logic [5:0] OP_REST  = 6'd22;
  localparam logic [5:0] OP_ADD   = 6'd23;
  localparam logic [5:0] OP_SUB   = 6'd24;
  localparam logic [5:0] OP_MUL   = 6'd25;
  localparam logic [5:0] OP_DIV   = 6'd26;
  localparam logic [5:0] OP_EQ    = 6'd27;
  localparam logic [5:0] OP_GT    = 6'd28;
  localparam logic [5:0] OP_GE    = 6'd29;
  localparam logic [5:0] OP_LT    = 6'd30;
  localparam logic [5:0] OP_LE    = 6'd31;
  localparam logic [5:0] OP_NE    = 6'd32;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_EMPTY = 3'd1;
  localparam logic [2:0] ERR_TAG   = 3'd2;
  localparam logic [2:0] ERR_OVF   = 3'd3;
  localparam logic [2:0] ERR_RANGE = 3'd4;
  localparam logic [2:0] ERR_DIV0  = 3'd5;
  localparam logic [2:0] ERR_UNSUP = 3'd6;

  localparam logic [1:0] TAG_NUM = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EXEC, S_READ2, S_EXEC2, S_MUL, S_DIV, S_WB, S_CLR, S_NIP, S_MOD
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic rd2;
    logic exec2;
    logic mul;
    logic div_start;
    logic wb;
    logic clr;
    logic mod_start;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic go_mul;
    logic go_div;
    logic go_rd2;
    logic go_clr;
    logic clr_done;
    logic div_done;
    logic mod_need;
    logic out_busy;
  } stat_t;

endpackage

>>> hdl/stack_machine_executor_core.sv
// Stack machine executor: one instruction word in, one status word out. An
// instruction is accepted, reads stack and memories, executes and resolves
// the next pointer; MUL adds a multiply step, DIV a bit-serial divider (both
// then write back), REST a second read and execute, and ALLOC clears call-stack
// slots one per cycle. A next pointer beyond program_length (other than
// exactly on it) is reduced on the same divider. The result register frees
// the input side once the result is loaded.
module stack_machine_executor_core #(
  parameter int DATA_DEPTH   = smx_pkg::DATA_DEPTH_DEF,
  parameter int CALL_DEPTH   = smx_pkg::CALL_DEPTH_DEF,
  parameter int GLOBAL_DEPTH = smx_pkg::GLOBAL_DEPTH_DEF,
  parameter int PROG_DEPTH   = smx_pkg::PROG_DEPTH_DEF,
  localparam int PW = $clog2(PROG_DEPTH),
  localparam int OW = ((PW + 38 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // opcode[5:0], operand_value[37:6], operand_tag[39:38]
  input  logic [smx_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // next_ip, halted, print_valid, print_value, syscall_request, error_code
  output logic [OW-1:0]             m_tdata,
  input  logic                      cfg_we,
  input  logic [smx_pkg::CFG_W-1:0] cfg_wdata
);

  smx_pkg::cmd_t  cmd;
  smx_pkg::stat_t st;

  smx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  smx_dpath #(
    .DATA_DEPTH   (DATA_DEPTH),
    .CALL_DEPTH   (CALL_DEPTH),
    .GLOBAL_DEPTH (GLOBAL_DEPTH),
    .PROG_DEPTH   (PROG_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> hdl/smx_div.sv
module smx_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        sgn,
  input  logic [31:0] dvd,
  input  logic [31:0] dvs,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem,
  output logic        ovf
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] q;
  logic [31:0] r;
  logic [31:0] dmag;
  logic        neg;
  logic        sgn_r;
  logic [32:0] sh;
  logic [32:0] trial;

  assign sh    = {r, q[31]};
  assign trial = sh - {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= (sgn && dvd[31]) ? -dvd : dvd;
      dmag  <= (sgn && dvs[31]) ? -dvs : dvs;
      neg   <= sgn & (dvd[31] ^ dvs[31]);
      sgn_r <= sgn;
      r     <= '0;
    end else if (busy) begin
      if (!trial[32]) begin
        r <= trial[31:0];
        q <= {q[30:0], 1'b1};
      end else begin
        r <= sh[31:0];
        q <= {q[30:0], 1'b0};
      end
    end
  end

  assign quo = neg ? -q : q;
  assign rem = r;
  assign ovf = sgn_r & ~neg & q[31];

endmodule

>>> hdl/smx_dpath.sv
module smx_dpath #(
  parameter int DATA_DEPTH   = smx_pkg::DATA_DEPTH_DEF,
  parameter int CALL_DEPTH   = smx_pkg::CALL_DEPTH_DEF,
  parameter int GLOBAL_DEPTH = smx_pkg::GLOBAL_DEPTH_DEF,
  parameter int PROG_DEPTH   = smx_pkg::PROG_DEPTH_DEF,
  localparam int PW = $clog2(PROG_DEPTH),
  localparam int OW = ((PW + 38 + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  smx_pkg::cmd_t             cmd,
  output smx_pkg::stat_t            st,
  input  logic [smx_pkg::IN_W-1:0]  in_data,
  input  logic                      cfg_we,
  input  logic [smx_pkg::CFG_W-1:0] cfg_wdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OW-1:0]             m_tdata
);

  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int DCW = $clog2(DATA_DEPTH + 1);
  localparam int CAW = $clog2(CALL_DEPTH);
  localparam int CCW = $clog2(CALL_DEPTH + 1);
  localparam int GAW = $clog2(GLOBAL_DEPTH);
  localparam int LW  = PW + 1;
  localparam int PTW = CCW + 2;
  localparam int EW  = smx_pkg::ENT_W;

  logic [5:0]     op;
  logic [31:0]    val;
  logic [1:0]     tag;
  logic [PW-1:0]  ip;
  logic [LW-1:0]  len;
  logic [DCW-1:0] dc;
  logic [CCW-1:0] cc;
  logic [CCW-1:0] fb;

  logic [EW-1:0] dmem [DATA_DEPTH];
  logic [EW-1:0] cmem [CALL_DEPTH];
  logic [EW-1:0] gmem [GLOBAL_DEPTH];
  logic [EW-1:0] d_top;
  logic [EW-1:0] d_sec;
  logic [EW-1:0] c_rd;
  logic [EW-1:0] g_rd;

  logic [31:0] tgt;
  logic        hold;
  logic        jmp;
  logic        rinc;
  logic [2:0]  err;
  logic        halt;
  logic        pv;
  logic        sys;
  logic [31:0] pval;
  logic [31:0] ar_val;
  logic        ar_ovf;
  logic        div_mod;

  logic [PTW-1:0] clr_ptr;
  logic [PTW-1:0] clr_end;
  logic [1:0]     clr_tag;

  logic          o_valid;
  logic [PW-1:0] o_nip;
  logic          o_halt;
  logic          o_pv;
  logic [31:0]   o_pval;
  logic          o_sys;
  logic [2:0]    o_err;

  logic [DCW-1:0] dc_m1;
  logic [DCW-1:0] dc_m2;
  logic [CCW-1:0] cc_m1;
  logic [32:0]    slot;
  logic           slot_ok;
  logic           g_ok;
  logic [CAW-1:0] c_ra;
  logic [GAW-1:0] g_ra;
  logic [31:0]    top_v;
  logic [31:0]    sec_v;
  logic           d_full;
  logic           d_empty;
  logic [32:0]    add33;
  logic [32:0]    sub33;
  logic [63:0]    prod;

  logic           x_dwe;
  logic [DAW-1:0] x_dwa;
  logic [EW-1:0]  x_dwd;
  logic [DCW-1:0] x_dc;
  logic           x_cwe;
  logic [CAW-1:0] x_cwa;
  logic [EW-1:0]  x_cwd;
  logic [CCW-1:0] x_cc;
  logic [CCW-1:0] x_fb;
  logic           x_gwe;
  logic [GAW-1:0] x_gwa;
  logic [EW-1:0]  x_gwd;
  logic [31:0]    x_tgt;
  logic           x_hold;
  logic           x_jmp;
  logic           x_rinc;
  logic [2:0]     x_err;
  logic           x_halt;
  logic           x_pv;
  logic [31:0]    x_pval;
  logic           x_sys;
  logic           x_mul;
  logic           x_div;
  logic           x_rd2;
  logic           x_clr;
  logic           x_push;
  logic [32:0]    alloc_sum;

  logic           e2_ok;
  logic           dw_en;
  logic [DAW-1:0] dw_a;
  logic [EW-1:0]  dw_d;
  logic           cw_en;
  logic [CAW-1:0] cw_a;
  logic [EW-1:0]  cw_d;

  logic           div_start;
  logic           div_sgn;
  logic [31:0]    div_dvd;
  logic [31:0]    div_dvs;
  logic           div_done;
  logic [31:0]    div_quo;
  logic [31:0]    div_rem;
  logic           div_ovf;

  logic           out_busy;
  logic           t_ge;
  logic           t_eq;
  logic [PW-1:0]  base;
  logic [LW-1:0]  base1;
  logic [PW-1:0]  nip;
  logic [2:0]     fin_err;

  assign dc_m1   = dc - DCW'(1);
  assign dc_m2   = dc - DCW'(2);
  assign cc_m1   = cc - CCW'(1);
  assign slot    = {val[31], val} + 33'(fb);
  assign slot_ok = !slot[32] && (slot < 33'(CALL_DEPTH));
  assign g_ok    = !val[31] && (val < 32'(GLOBAL_DEPTH));
  assign c_ra    = (op == smx_pkg::OP_RET) ? cc_m1[CAW-1:0] : slot[CAW-1:0];
  assign top_v   = d_top[31:0];
  assign sec_v   = d_sec[31:0];
  assign g_ra    = cmd.rd2 ? top_v[GAW-1:0] : val[GAW-1:0];
  assign d_full  = dc >= DCW'(DATA_DEPTH);
  assign d_empty = dc == '0;
  assign add33   = {sec_v[31], sec_v} + {top_v[31], top_v};
  assign sub33   = {sec_v[31], sec_v} - {top_v[31], top_v};
  assign prod    = $signed(sec_v) * $signed(top_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LW'(1);
    end else if (cfg_we) begin
      if (cfg_wdata == '0) begin
        len <= LW'(1);
      end else if (32'(cfg_wdata) > 32'(PROG_DEPTH)) begin
        len <= LW'(PROG_DEPTH);
      end else begin
        len <= LW'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_data[5:0];
      val <= in_data[37:6];
      tag <= in_data[39:38];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd || cmd.rd2) begin
      d_top <= dmem[dc_m1[DAW-1:0]];
      d_sec <= dmem[dc_m2[DAW-1:0]];
      c_rd  <= cmem[c_ra];
      g_rd  <= gmem[g_ra];
    end
  end

  always_comb begin
    x_dwe = 1'b0; x_dwa = dc[DAW-1:0]; x_dwd = '0; x_dc = dc;
    x_cwe = 1'b0; x_cwa = cc[CAW-1:0]; x_cwd = '0; x_cc = cc; x_fb = fb;
    x_gwe = 1'b0; x_gwa = val[GAW-1:0]; x_gwd = d_top;
    x_tgt = 32'(ip) + 32'd1;
    x_hold = 1'b0; x_jmp = 1'b0; x_rinc = 1'b0;
    x_err = smx_pkg::ERR_OK; x_halt = 1'b0; x_pv = 1'b0; x_pval = '0; x_sys = 1'b0;
    x_mul = 1'b0; x_div = 1'b0; x_rd2 = 1'b0; x_clr = 1'b0; x_push = 1'b0;
    alloc_sum = 33'(val) + 33'(cc);
    case (op)
      smx_pkg::OP_PUSH: begin
        if (d_full) x_err = smx_pkg::ERR_OVF;
        else begin x_push = 1'b1; x_dwd = {tag, val}; end
      end
      smx_pkg::OP_RET: begin
        if (cc == '0) x_err = smx_pkg::ERR_EMPTY;
        else begin
          x_cc = cc_m1; x_tgt = c_rd[31:0]; x_jmp = 1'b1; x_rinc = 1'b1;
        end
      end
      smx_pkg::OP_RCL: begin
        if (!g_ok) x_err = smx_pkg::ERR_RANGE;
        else if (d_full) x_err = smx_pkg::ERR_OVF;
        else begin x_push = 1'b1; x_dwd = g_rd; end
      end
      smx_pkg::OP_END: begin
        x_halt = 1'b1; x_hold = 1'b1;
      end
      smx_pkg::OP_RCE: begin
        if (!slot_ok) x_err = smx_pkg::ERR_RANGE;
        else if (d_full) x_err = smx_pkg::ERR_OVF;
        else begin x_push = 1'b1; x_dwd = c_rd; end
      end
      smx_pkg::OP_FREE: begin
        if (val[31] || val > 32'(cc)) x_err = smx_pkg::ERR_RANGE;
        else x_cc = cc - CCW'(val);
      end
      smx_pkg::OP_ALLOC: begin
        if (val[31]) x_err = smx_pkg::ERR_RANGE;
        else if (alloc_sum > 33'(CALL_DEPTH)) x_err = smx_pkg::ERR_OVF;
        else begin x_cc = CCW'(alloc_sum); x_clr = 1'b1; end
      end
      smx_pkg::OP_JMP: begin
        x_tgt = val; x_jmp = 1'b1;
      end
      smx_pkg::OP_REC, smx_pkg::OP_DEP, smx_pkg::OP_ATAC, smx_pkg::OP_MOV: begin
        x_sys = 1'b1;
      end
      smx_pkg::OP_POP, smx_pkg::OP_DUP, smx_pkg::OP_STO, smx_pkg::OP_STL: begin
        if (d_empty) x_err = smx_pkg::ERR_EMPTY;
        else begin
          case (op)
            smx_pkg::OP_POP: x_dc = dc_m1;
            smx_pkg::OP_DUP: begin
              if (d_full) x_err = smx_pkg::ERR_OVF;
              else begin x_push = 1'b1; x_dwd = d_top; end
            end
            smx_pkg::OP_STO: begin
              if (!g_ok) x_err = smx_pkg::ERR_RANGE;
              else begin x_gwe = 1'b1; x_dc = dc_m1; end
            end
            default: begin
              if (!slot_ok) x_err = smx_pkg::ERR_RANGE;
              else begin
                x_cwe = 1'b1; x_cwa = slot[CAW-1:0]; x_cwd = d_top; x_dc = dc_m1;
              end
            end
          endcase
        end
      end
      smx_pkg::OP_JIT, smx_pkg::OP_JIF, smx_pkg::OP_CALL, smx_pkg::OP_PRN,
      smx_pkg::OP_TOP, smx_pkg::OP_SAVE, smx_pkg::OP_REST: begin
        if (d_empty) x_err = smx_pkg::ERR_EMPTY;
        else if (d_top[33:32] != smx_pkg::TAG_NUM) x_err = smx_pkg::ERR_TAG;
        else begin
          case (op)
            smx_pkg::OP_JIT, smx_pkg::OP_JIF: begin
              x_dc = dc_m1;
              if ((op == smx_pkg::OP_JIT) == (top_v != '0)) begin
                x_tgt = val; x_jmp = 1'b1;
              end
            end
            smx_pkg::OP_CALL: begin
              if (cc >= CCW'(CALL_DEPTH)) x_err = smx_pkg::ERR_OVF;
              else begin
                x_fb = cc; x_cwe = 1'b1; x_cwd = {smx_pkg::TAG_NUM, 32'(ip)};
                x_cc = cc + CCW'(1); x_tgt = val; x_jmp = 1'b1;
              end
            end
            smx_pkg::OP_PRN: begin
              x_dc = dc_m1; x_pv = 1'b1; x_pval = top_v;
            end
            smx_pkg::OP_TOP: begin
              if (top_v[31] || top_v > 32'(CALL_DEPTH)) x_err = smx_pkg::ERR_RANGE;
              else begin x_dc = dc_m1; x_cc = CCW'(top_v); end
            end
            smx_pkg::OP_SAVE: begin
              if (top_v[31] || top_v >= 32'(GLOBAL_DEPTH)) x_err = smx_pkg::ERR_RANGE;
              else begin
                x_dc = dc_m1; x_gwe = 1'b1; x_gwa = top_v[GAW-1:0];
                x_gwd = {smx_pkg::TAG_NUM, 32'(fb)};
              end
            end
            default: begin
              if (top_v[31] || top_v >= 32'(GLOBAL_DEPTH)) x_err = smx_pkg::ERR_RANGE;
              else x_rd2 = 1'b1;
            end
          endcase
        end
      end
      smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV,
      smx_pkg::OP_EQ, smx_pkg::OP_GT, smx_pkg::OP_GE, smx_pkg::OP_LT,
      smx_pkg::OP_LE, smx_pkg::OP_NE: begin
        if (dc < DCW'(2)) x_err = smx_pkg::ERR_EMPTY;
        else if (d_top[33:32] != smx_pkg::TAG_NUM || d_sec[33:32] != smx_pkg::TAG_NUM)
          x_err = smx_pkg::ERR_TAG;
        else begin
          x_dwa = dc_m2[DAW-1:0];
          case (op)
            smx_pkg::OP_MUL: x_mul = 1'b1;
            smx_pkg::OP_DIV: begin
              if (top_v == '0) x_err = smx_pkg::ERR_DIV0;
              else x_div = 1'b1;
            end
            default: begin
              x_dwe = 1'b1; x_dc = dc_m1;
              case (op)
                smx_pkg::OP_ADD: begin
                  x_dwd = {smx_pkg::TAG_NUM, add33[31:0]};
                  if (add33[32] != add33[31]) x_err = smx_pkg::ERR_OVF;
                end
                smx_pkg::OP_SUB: begin
                  x_dwd = {smx_pkg::TAG_NUM, sub33[31:0]};
                  if (sub33[32] != sub33[31]) x_err = smx_pkg::ERR_OVF;
                end
                smx_pkg::OP_EQ: x_dwd = EW'(sec_v == top_v);
                smx_pkg::OP_GT: x_dwd = EW'($signed(sec_v) > $signed(top_v));
                smx_pkg::OP_GE: x_dwd = EW'($signed(sec_v) >= $signed(top_v));
                smx_pkg::OP_LT: x_dwd = EW'($signed(sec_v) < $signed(top_v));
                smx_pkg::OP_LE: x_dwd = EW'($signed(sec_v) <= $signed(top_v));
                default:        x_dwd = EW'(sec_v != top_v);
              endcase
            end
          endcase
        end
      end
      default: x_err = smx_pkg::ERR_UNSUP;
    endcase
    if (x_push) begin
      x_dwe = 1'b1; x_dwa = dc[DAW-1:0]; x_dc = dc + DCW'(1);
    end
  end

  assign e2_ok = !g_rd[31] && (g_rd[31:0] <= 32'(CALL_DEPTH));

  always_comb begin
    dw_en = 1'b0; dw_a = x_dwa; dw_d = x_dwd;
    if (cmd.exec) dw_en = x_dwe;
    else if (cmd.wb) begin
      dw_en = 1'b1; dw_a = dc_m2[DAW-1:0]; dw_d = {smx_pkg::TAG_NUM, ar_val};
    end
    cw_en = 1'b0; cw_a = x_cwa; cw_d = x_cwd;
    if (cmd.exec) cw_en = x_cwe;
    else if (cmd.clr && !st.clr_done) begin
      cw_en = 1'b1; cw_a = clr_ptr[CAW-1:0]; cw_d = {clr_tag, 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (dw_en) dmem[dw_a] <= dw_d;
  end

  always_ff @(posedge clk) begin
    if (cw_en) cmem[cw_a] <= cw_d;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && x_gwe) gmem[x_gwa] <= x_gwd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dc <= '0;
      cc <= '0;
      fb <= '0;
    end else if (cmd.exec) begin
      dc <= x_dc;
      cc <= x_cc;
      fb <= x_fb;
    end else if (cmd.wb) begin
      dc <= dc_m1;
    end else if (cmd.exec2 && e2_ok) begin
      dc <= dc_m1;
      fb <= CCW'(g_rd[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      tgt  <= x_tgt;
      hold <= x_hold;
      jmp  <= x_jmp;
      rinc <= x_rinc;
      err  <= x_err;
      halt <= x_halt;
      pv   <= x_pv;
      pval <= x_pval;
      sys  <= x_sys;
      clr_ptr <= PTW'(fb) + PTW'(1);
      clr_end <= PTW'(fb) + PTW'(val[CCW-1:0]);
      clr_tag <= tag;
    end else begin
      if (cmd.exec2 && !e2_ok) err <= smx_pkg::ERR_RANGE;
      if (cmd.wb && ar_ovf) err <= smx_pkg::ERR_OVF;
      if (cmd.clr && !st.clr_done) clr_ptr <= clr_ptr + PTW'(1);
      if (cmd.mod_start && jmp) err <= smx_pkg::ERR_RANGE;
      if (div_done && div_mod) tgt <= div_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      ar_val <= prod[31:0];
      ar_ovf <= (prod[63:31] != '0) && (prod[63:31] != '1);
    end else if (div_done && !div_mod) begin
      ar_val <= div_quo;
      ar_ovf <= div_ovf;
    end
  end

  assign div_start = cmd.div_start | cmd.mod_start;
  assign div_sgn   = cmd.div_start;
  assign div_dvd   = cmd.div_start ? sec_v : tgt;
  assign div_dvs   = cmd.div_start ? top_v : 32'(len);

  always_ff @(posedge clk) begin
    if (div_start) div_mod <= cmd.mod_start;
  end

  smx_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sgn   (div_sgn),
    .dvd   (div_dvd),
    .dvs   (div_dvs),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem),
    .ovf   (div_ovf)
  );

  assign t_ge  = tgt >= 32'(len);
  assign t_eq  = tgt == 32'(len);
  assign base  = t_eq ? '0 : tgt[PW-1:0];
  assign base1 = LW'(base) + LW'(1);

  always_comb begin
    if (hold) nip = ip;
    else if (rinc) nip = (base1 == len) ? '0 : base1[PW-1:0];
    else nip = base;
  end

  assign fin_err  = (jmp && t_eq) ? smx_pkg::ERR_RANGE : err;
  assign out_busy = o_valid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ip      <= '0;
      o_valid <= 1'b0;
    end else if (cmd.fin) begin
      ip      <= nip;
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      o_nip  <= nip;
      o_halt <= halt;
      o_pv   <= pv;
      o_pval <= pval;
      o_sys  <= sys;
      o_err  <= fin_err;
    end
  end

  assign st.go_mul   = x_mul;
  assign st.go_div   = x_div;
  assign st.go_rd2   = x_rd2;
  assign st.go_clr   = x_clr;
  assign st.clr_done = (clr_ptr > clr_end) || (clr_ptr >= PTW'(CALL_DEPTH));
  assign st.div_done = div_done;
  assign st.mod_need = !hold && t_ge && !t_eq;
  assign st.out_busy = out_busy;

  assign m_tvalid = o_valid;
  assign m_tdata  = OW'({o_err, o_sys, o_pval, o_pv, o_halt, o_nip});

`ifndef SYNTHESIS
  a_dc_bound: assert property (@(posedge clk) disable iff (rst)
    dc <= DCW'(DATA_DEPTH))
    else $error("data stack count beyond depth");

  a_cc_bound: assert property (@(posedge clk) disable iff (rst)
    cc <= CCW'(CALL_DEPTH) && fb <= CCW'(CALL_DEPTH))
    else $error("call stack count or frame base beyond depth");

  a_nip_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fin && !hold |=> LW'(o_nip) < len)
    else $error("next pointer outside program");
`endif

endmodule

>>> hdl/smx_ctrl.sv
module smx_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  smx_pkg::stat_t st,
  output smx_pkg::cmd_t  cmd
);

  smx_pkg::state_t state;
  smx_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smx_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      smx_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = smx_pkg::S_READ;
        end
      end
      smx_pkg::S_READ: begin
        cmd.rd     = 1'b1;
        state_next = smx_pkg::S_EXEC;
      end
      smx_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.go_mul) state_next = smx_pkg::S_MUL;
        else if (st.go_div) begin
          cmd.div_start = 1'b1;
          state_next    = smx_pkg::S_DIV;
        end
        else if (st.go_rd2) state_next = smx_pkg::S_READ2;
        else if (st.go_clr) state_next = smx_pkg::S_CLR;
        else state_next = smx_pkg::S_NIP;
      end
      smx_pkg::S_READ2: begin
        cmd.rd2    = 1'b1;
        state_next = smx_pkg::S_EXEC2;
      end
      smx_pkg::S_EXEC2: begin
        cmd.exec2  = 1'b1;
        state_next = smx_pkg::S_NIP;
      end
      smx_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = smx_pkg::S_WB;
      end
      smx_pkg::S_DIV: begin
        if (st.div_done) state_next = smx_pkg::S_WB;
      end
      smx_pkg::S_WB: begin
        cmd.wb     = 1'b1;
        state_next = smx_pkg::S_NIP;
      end
      smx_pkg::S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_next = smx_pkg::S_NIP;
      end
      smx_pkg::S_NIP: begin
        if (st.mod_need) begin
          cmd.mod_start = 1'b1;
          state_next    = smx_pkg::S_MOD;
        end else if (!st.out_busy) begin
          cmd.fin    = 1'b1;
          state_next = smx_pkg::S_IDLE;
        end
      end
      smx_pkg::S_MOD: begin
        if (st.div_done) state_next = smx_pkg::S_NIP;
      end
      default: state_next = smx_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.rd, cmd.exec, cmd.rd2, cmd.exec2, cmd.mul,
              cmd.wb, cmd.clr, cmd.mod_start, cmd.fin}))
    else $error("more than one datapath command");

  a_fin_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> !st.mod_need && !st.out_busy)
    else $error("result issued while output busy or pointer unreduced");

  a_load_read: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.rd)
    else $error("accepted word not followed by read");
`endif

endmodule
